// File: rtl/lz77h_pkg.sv
// Shared types and constants of the LZ77 hash chain insertion block.
package lz77h_pkg;

	localparam int WIN_W = 15;
	localparam int OUT_W = 15;
	localparam logic [31:0] HASH_MULT = 32'h1E35A7BD;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;
	localparam int FIFO_CW = 3;

	typedef struct packed {
		logic valid;
		logic [WIN_W-1:0] pos;
	} ins_t;

	typedef struct packed {
		logic [OUT_W-1:0] chain_link;
		logic [OUT_W-1:0] bucket;
		logic [WIN_W-1:0] position;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} res_t;

endpackage

// File: rtl/lz77h_hasher.sv
// Byte window, position counter and hash multiplier stage.
module lz77h_hasher #(
	parameter int BUCKET_W = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic take,
	input  logic [7:0] data_byte,
	input  logic buffer_start,
	output lz77h_pkg::ins_t ins,
	output logic [BUCKET_W-1:0] bucket
);

	logic [23:0] recent_q;
	logic [1:0] seen_q;
	logic [lz77h_pkg::WIN_W-1:0] pos_q;
	logic v_s1;
	logic [lz77h_pkg::WIN_W-1:0] pos_s1;
	logic [31:0] prod_s1;

	logic [23:0] eff_recent;
	logic [1:0] eff_seen;
	logic [lz77h_pkg::WIN_W-1:0] eff_pos;
	logic [31:0] word;
	logic full;

	assign eff_recent = buffer_start ? 24'd0 : recent_q;
	assign eff_seen = buffer_start ? 2'd0 : seen_q;
	assign eff_pos = buffer_start ? '0 : pos_q;
	assign word = {data_byte, eff_recent};
	assign full = (eff_seen == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q <= '0;
			seen_q <= '0;
			pos_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take && full;
			if (take) begin
				recent_q <= {data_byte, eff_recent[23:8]};
				if (full) begin
					seen_q <= eff_seen;
					pos_q <= eff_pos + 1'b1;
				end else begin
					seen_q <= eff_seen + 2'd1;
					pos_q <= eff_pos;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pos_s1 <= eff_pos;
			prod_s1 <= word * lz77h_pkg::HASH_MULT;
		end
	end

	assign ins.valid = v_s1;
	assign ins.pos = pos_s1;
	assign bucket = prod_s1[31 -: BUCKET_W];

endmodule

// File: rtl/lz77h_head_table.sv
// Head table memory with clearing pass, read-modify-write and forwarding.
module lz77h_head_table #(
	parameter int BUCKET_W = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  lz77h_pkg::ins_t req,
	input  logic [BUCKET_W-1:0] req_bucket,
	output logic busy,
	output lz77h_pkg::res_t res
);

	localparam int DEPTH = 1 << BUCKET_W;

	logic [lz77h_pkg::WIN_W-1:0] mem [DEPTH];

	logic clear_q;
	logic [BUCKET_W-1:0] clr_cnt_q;
	logic v_s2;
	logic [lz77h_pkg::WIN_W-1:0] pos_s2;
	logic [BUCKET_W-1:0] bkt_s2;
	logic [lz77h_pkg::WIN_W-1:0] rd_s2;
	logic wv_q;
	logic [BUCKET_W-1:0] wbkt_q;
	logic [lz77h_pkg::WIN_W-1:0] wpos_q;

	logic [lz77h_pkg::WIN_W-1:0] old_head;
	logic [15:0] bkt_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q <= 1'b1;
			clr_cnt_q <= '0;
			v_s2 <= 1'b0;
			wv_q <= 1'b0;
		end else begin
			v_s2 <= req.valid;
			wv_q <= v_s2;
			if (clear_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == '1) begin
					clear_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		pos_s2 <= req.pos;
		bkt_s2 <= req_bucket;
		wbkt_q <= bkt_s2;
		wpos_q <= pos_s2;
	end

	// The read returns the contents before a write on the same edge.
	always_ff @(posedge clk) begin
		rd_s2 <= mem[req_bucket];
		if (clear_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (v_s2) begin
			mem[bkt_s2] <= pos_s2;
		end
	end

	assign old_head = (wv_q && (wbkt_q == bkt_s2)) ? wpos_q : rd_s2;
	assign bkt_ext = 16'(bkt_s2);

	assign busy = clear_q;
	assign res.valid = v_s2;
	assign res.item.position = pos_s2;
	assign res.item.bucket = bkt_ext[lz77h_pkg::OUT_W-1:0];
	assign res.item.chain_link = old_head;

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !req.valid)
		else $error("insertion request during clearing pass");

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !v_s2)
		else $error("insertion in flight during clearing pass");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clear_q) |-> $past(clr_cnt_q) == '1)
		else $error("clearing pass ended before the last entry");

endmodule

// File: rtl/lz77h_prev_table.sv
// Chain link memory, written with the old head at each inserted position.
module lz77h_prev_table (
	input  logic clk,
	input  lz77h_pkg::res_t res
);

	localparam int DEPTH = 1 << lz77h_pkg::WIN_W;

	logic [lz77h_pkg::OUT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (res.valid) begin
			mem[res.item.position] <= res.item.chain_link;
		end
	end

endmodule

// File: rtl/lz77h_out_fifo.sv
// Small result queue that decouples the insertion pipeline from the receiver.
module lz77h_out_fifo (
	input  logic clk,
	input  logic arst_n,
	input  lz77h_pkg::res_t push,
	output lz77h_pkg::item_t head,
	output logic head_valid,
	input  logic pop,
	output logic [lz77h_pkg::FIFO_CW-1:0] count
);

	lz77h_pkg::item_t mem [lz77h_pkg::FIFO_DEPTH];

	logic [lz77h_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [lz77h_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [lz77h_pkg::FIFO_CW-1:0] cnt_q;
	logic do_pop;

	assign head_valid = (cnt_q != '0);
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem[wr_ptr_q] <= push.item;
		end
	end

	assign head = mem[rd_ptr_q];
	assign count = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (cnt_q < lz77h_pkg::FIFO_CW'(lz77h_pkg::FIFO_DEPTH))
			|| do_pop)
		else $error("result queue overflow");

endmodule

// File: rtl/lz77_hash_chain_insert.sv
// Top level of the LZ77 hash chain insertion block.
//
// Bytes enter on the s_ channel, one byte per transaction, with s_tuser high
// on the first byte of a new buffer. From the fourth byte of a buffer on,
// each byte inserts the position of the four bytes ending with it into the
// hash chains and yields one result transaction on the m_ channel with the
// position, the bucket and the previous head of that bucket.
// A byte passes the hasher and head table stages into the result queue. The
// block takes one byte per cycle while s_tready is high: the head table is
// read one cycle and written the next, and the write of the preceding
// insertion is forwarded to a read of the same bucket. A four-entry result
// queue holds finished results; when the receiver stalls, s_tready drops
// once four results are queued or in flight. After reset the head table is
// cleared one entry per cycle; s_tready stays low until the pass is over.
module lz77_hash_chain_insert #(
	parameter int BUCKET_W = 15
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic s_tuser,         // [0] buffer_start
	output logic m_tvalid,
	input  logic m_tready,
	output logic [47:0] m_tdata   // [14:0] position, [29:15] bucket, [44:30] chain_link
);

	lz77h_pkg::ins_t ins;
	logic [BUCKET_W-1:0] bucket;
	logic busy;
	lz77h_pkg::res_t res;
	lz77h_pkg::item_t head;
	logic [lz77h_pkg::FIFO_CW-1:0] count;
	logic [lz77h_pkg::FIFO_CW:0] in_flight;
	logic take;

	assign in_flight = {1'b0, count} + (lz77h_pkg::FIFO_CW + 1)'(ins.valid)
		+ (lz77h_pkg::FIFO_CW + 1)'(res.valid);
	assign s_tready = !busy
		&& (in_flight < (lz77h_pkg::FIFO_CW + 1)'(lz77h_pkg::FIFO_DEPTH));
	assign take = s_tvalid && s_tready;

	lz77h_hasher #(
		.BUCKET_W(BUCKET_W)
	) u_hasher (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.data_byte(s_tdata),
		.buffer_start(s_tuser),
		.ins(ins),
		.bucket(bucket)
	);

	lz77h_head_table #(
		.BUCKET_W(BUCKET_W)
	) u_head_table (
		.clk(clk),
		.arst_n(arst_n),
		.req(ins),
		.req_bucket(bucket),
		.busy(busy),
		.res(res)
	);

	lz77h_prev_table u_prev_table (
		.clk(clk),
		.res(res)
	);

	lz77h_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res),
		.head(head),
		.head_valid(m_tvalid),
		.pop(m_tready),
		.count(count)
	);

	assign m_tdata = {3'b000, head.chain_link, head.bucket, head.position};

endmodule

// File: tb/lz77_hash_chain_insert_tb.sv
// Self-checking testbench for the LZ77 hash chain insertion block.
module lz77_hash_chain_insert_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUCKET_W = 15;

	typedef enum int {PACE_FULL, PACE_NORMAL} pace_e;

	class hash_chain_tracker;
		logic [lz77h_pkg::WIN_W-1:0] head_tbl [];
		logic [23:0] last_bytes;
		int unsigned byte_count;
		logic [lz77h_pkg::WIN_W-1:0] next_pos;
		lz77h_pkg::item_t pending_inserts [$];
		int mismatches;

		function new();
			head_tbl = new[1 << BUCKET_W];
			foreach (head_tbl[i]) head_tbl[i] = '0;
			last_bytes = '0;
			byte_count = 0;
			next_pos = '0;
			mismatches = 0;
		endfunction

		function void take_byte(logic [7:0] b, logic first);
			logic [31:0] word;
			logic [31:0] prod;
			int unsigned h;
			lz77h_pkg::item_t ins;
			if (first) begin
				byte_count = 0;
				next_pos = '0;
				last_bytes = '0;
			end
			if (byte_count >= 3) begin
				word = {b, last_bytes};
				prod = word * lz77h_pkg::HASH_MULT;
				h = prod >> (32 - BUCKET_W);
				ins.position = next_pos;
				ins.bucket = h[lz77h_pkg::OUT_W-1:0];
				ins.chain_link = head_tbl[h];
				head_tbl[h] = next_pos;
				pending_inserts.push_back(ins);
				next_pos = next_pos + 1'b1;
			end else begin
				byte_count++;
			end
			last_bytes = {b, last_bytes[23:8]};
		endfunction

		function void compare_field(string name, logic [14:0] want, logic [14:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_insertion(logic [47:0] d);
			lz77h_pkg::item_t want;
			lz77h_pkg::item_t got;
			got = lz77h_pkg::item_t'(d[44:0]);
			if (pending_inserts.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual %h", $time, d);
				mismatches++;
				return;
			end
			want = pending_inserts.pop_front();
			compare_field("position", want.position, got.position);
			compare_field("bucket", want.bucket, got.bucket);
			compare_field("chain_link", want.chain_link, got.chain_link);
			if (d[47:45] !== 3'b000) begin
				$display("%0t: padding mismatch, expected 0, actual %h", $time, d[47:45]);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;

	pace_e pace = PACE_NORMAL;
	logic hold_req = 1'b0;
	logic [7:0] alpha [4] = '{8'h00, 8'h3C, 8'hA5, 8'hFF};
	hash_chain_tracker sb = new();

	lz77_hash_chain_insert #(
		.BUCKET_W(BUCKET_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		case (pace)
			PACE_FULL: begin
				return 0;
			end
			default: begin
				if (r < 70)
					return 0;
				else if (r < 95)
					return $urandom_range(1, 4);
				else
					return $urandom_range(10, 40);
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic first);
		int g;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		do @(posedge clk); while (!s_tready);
		sb.take_byte(b, first);
		g = idle_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	initial begin
		int stall_left;
		bit stalled;
		stall_left = 0;
		stalled = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_insertion(m_tdata);
			if (hold_req && !stalled) begin
				stall_left = 300;
				stalled = 1'b1;
			end
			if (stall_left == 0)
				stall_left = idle_len();
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		int r;
		int len;
		int sent;
		bit held;
		bit narrow;
		logic [7:0] b;
		logic [7:0] pattern [6];
		pattern = '{8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Short buffer, runs of one value that hit the same bucket back to back,
		// a mixed pattern, and a repeat of an earlier word in a new buffer.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		for (i = 0; i < 6; i++)
			send_byte(8'hFF, i == 0);
		for (i = 0; i < 5; i++)
			send_byte(8'h00, i == 0);
		for (i = 0; i < 6; i++)
			send_byte(pattern[i], i == 0);
		for (i = 0; i < 4; i++)
			send_byte(8'h00, i == 0);

		sent = 0;
		held = 1'b0;
		while (sent < 380) begin
			if (!held && sent >= 150) begin
				held = 1'b1;
				pace = PACE_FULL;
				hold_req = 1'b1;
				for (i = 0; i < 24; i++)
					send_byte(alpha[$urandom_range(0, 3)], i == 0);
				sent += 24;
			end
			r = $urandom_range(0, 99);
			pace = (r < 20) ? PACE_FULL : PACE_NORMAL;
			r = $urandom_range(0, 99);
			if (r < 15)
				len = $urandom_range(1, 3);
			else if (r < 85)
				len = $urandom_range(4, 30);
			else
				len = $urandom_range(31, 80);
			narrow = 1'($urandom_range(0, 1));
			for (i = 0; i < len; i++) begin
				b = narrow ? alpha[$urandom_range(0, 3)] : 8'($urandom);
				send_byte(b, i == 0);
			end
			sent += len;
		end
		s_tvalid <= 1'b0;

		while (sb.pending_inserts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
